// ===== rtl/sfs_pkg.sv =====
// Shared types and constants for the sprite sheet frame sequencer.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package sfs_pkg;

  // Fixed-point UV format: unsigned Q1.16
  localparam int UV_FRAC_BITS = 16;
  localparam int UV_W         = UV_FRAC_BITS + 1;
  localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << UV_FRAC_BITS;

  // Field and register widths
  localparam int ACTION_W   = 2;
  localparam int DELTA_W    = 16;
  localparam int COUNT_W    = 7;
  localparam int TOTAL_W    = 2 * COUNT_W;
  localparam int INTERVAL_W = 24;
  localparam int PERIOD_W   = TOTAL_W + INTERVAL_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = INTERVAL_W;

  // Input action codes; code 3 is ignored
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_PLAY = 2'd1,
    ACT_STOP = 2'd2
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS  = 2'd0,
    CFG_ROWS     = 2'd1,
    CFG_INTERVAL = 2'd2,
    CFG_LOOP     = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PERIOD,
    ST_DIV,
    ST_POST,
    ST_REWIND,
    ST_MUL_U,
    ST_MUL_V,
    ST_DONE
  } state_t;

  // What the running division computes
  typedef enum logic [2:0] {
    DT_WRAP,
    DT_FRAME,
    DT_COLROW,
    DT_SCALE_U,
    DT_SCALE_V
  } div_tag_t;

endpackage

`default_nettype wire

// ===== rtl/sfs_if.sv =====
// Valid/ready channel interfaces for the sprite sheet frame sequencer.
// Depends on sfs_pkg for field widths.
`default_nettype none

interface sfs_in_if import sfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DELTA_W-1:0]  delta_time;

  modport source (output valid, action, delta_time, input ready);
  modport sink   (input valid, action, delta_time, output ready);
endinterface

interface sfs_out_if import sfs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [UV_W-1:0] u_scale;
  logic [UV_W-1:0] v_scale;
  logic [UV_W-1:0] u_offset;
  logic [UV_W-1:0] v_offset;
  logic            is_playing;
  logic            is_finished;

  modport source (output valid, u_scale, v_scale, u_offset, v_offset, is_playing,
                  is_finished, input ready);
  modport sink   (input valid, u_scale, v_scale, u_offset, v_offset, is_playing,
                  is_finished, output ready);
endinterface

`default_nettype wire

// ===== rtl/sprite_sheet_frame_sequencer_top.sv =====
// Sprite sheet frame sequencer: steps a UV transform through sheet frames.
// Depends on sfs_pkg and the channel interfaces in sfs_if.sv.
//
// Usage:
//   in_ch carries one transaction per command: a time tick with a delta, play or stop.
//   out_ch returns exactly one transaction per input: UV scale and offset in Q1.16
//   plus the playing and finished flags. The cfg_ port writes the sheet columns,
//   rows, frame interval and loop mode, one register per cycle with cfg_we high.
// Sequencing:
//   One item at a time. All divisions run through one restoring divider that
//   retires one quotient bit per cycle.
//   Ignored items and no-op commands skip the divider and go straight to the result.
//   A play or stop that changes the state runs two divisions on a valid sheet.
//   A live tick runs four (one-shot) or five (loop) divisions plus two
//   multiply steps; a one-shot tick past the last frame rewinds instead.
// Reset:
//   Synchronous, active low. Sheet is 1 x 1, interval 0, one-shot mode, stopped,
//   scales at 1.0 and offsets at 0.
// Stalls:
//   A finished result sits in the output register; the next input is taken
//   meanwhile, and the block holds its following result until out_ch.ready.
`default_nettype none

module sprite_sheet_frame_sequencer_top import sfs_pkg::*; #(
  parameter int ELAPSED_BITS = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sfs_in_if.sink                     in_ch,
  sfs_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int N     = ELAPSED_BITS;
  localparam int DV_W  = PERIOD_W;
  localparam int CNT_W = $clog2(ELAPSED_BITS + 1);

  // Control state
  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  play_r, play_nxt;
  logic                  fin_r, fin_nxt;
  logic [N-1:0]          elapsed_r, elapsed_nxt;
  logic [UV_W-1:0]       scale_u_r, scale_u_nxt;
  logic [UV_W-1:0]       scale_v_r, scale_v_nxt;
  logic [UV_W-1:0]       shift_u_r, shift_u_nxt;
  logic [UV_W-1:0]       shift_v_r, shift_v_nxt;
  logic [COUNT_W-1:0]    cols_r;
  logic [COUNT_W-1:0]    rows_r;
  logic [INTERVAL_W-1:0] intv_r;
  logic                  loop_r;

  // Payload and divider working registers
  logic [ACTION_W-1:0]   action_r, action_nxt;
  logic [DELTA_W-1:0]    delta_r, delta_nxt;
  logic [TOTAL_W-1:0]    total_r, total_nxt;
  logic [COUNT_W-1:0]    col_r, col_nxt;
  logic [COUNT_W-1:0]    row_r, row_nxt;
  logic [N-1:0]          dvd_r, dvd_nxt;
  logic [DV_W-1:0]       dvs_r, dvs_nxt;
  logic [DV_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  div_tag_t              tag_r, tag_nxt;
  logic                  rew_r, rew_nxt;
  logic [UV_W-1:0]       o_u_scale_r, o_u_scale_nxt;
  logic [UV_W-1:0]       o_v_scale_r, o_v_scale_nxt;
  logic [UV_W-1:0]       o_u_offset_r, o_u_offset_nxt;
  logic [UV_W-1:0]       o_v_offset_r, o_v_offset_nxt;
  logic                  o_play_r, o_play_nxt;
  logic                  o_fin_r, o_fin_nxt;

  // Shared decisions
  logic                  sheet_ok;
  logic                  tick_go;
  logic                  out_free;
  logic                  frame_over;
  logic                  div_last;
  logic [DV_W:0]         trial;
  logic                  div_ge;
  logic [N:0]            sum_ext;
  logic [N-1:0]          elapsed_sat;
  logic [PERIOD_W-1:0]   period;

  assign sheet_ok    = (cols_r != '0) && (rows_r != '0);
  assign tick_go     = play_r && sheet_ok && (intv_r != '0) && (loop_r || !fin_r);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign frame_over  = !loop_r && (dvd_r >= N'(total_r));
  assign div_last    = (cnt_r == CNT_W'(1));
  assign trial       = {rem_r, dvd_r[N-1]};
  assign div_ge      = (trial >= {1'b0, dvs_r});
  assign sum_ext     = {1'b0, elapsed_r} + (N+1)'(delta_r);
  assign elapsed_sat = sum_ext[N] ? '1 : sum_ext[N-1:0];
  assign period      = PERIOD_W'(total_r) * PERIOD_W'(intv_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (action_r)
          ACT_TICK: state_nxt = tick_go ? ST_PERIOD : ST_DONE;
          ACT_PLAY: state_nxt = play_r ? ST_DONE : ST_REWIND;
          ACT_STOP: state_nxt = play_r ? ST_REWIND : ST_DONE;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_PERIOD: state_nxt = ST_DIV;
      ST_DIV:    if (div_last) state_nxt = ST_POST;
      ST_POST: begin
        unique case (tag_r)
          DT_WRAP:    state_nxt = ST_DIV;
          DT_FRAME:   state_nxt = frame_over ? ST_REWIND : ST_DIV;
          DT_COLROW:  state_nxt = ST_DIV;
          DT_SCALE_U: state_nxt = ST_DIV;
          DT_SCALE_V: state_nxt = rew_r ? ST_DONE : ST_MUL_U;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_REWIND: state_nxt = sheet_ok ? ST_DIV : ST_DONE;
      ST_MUL_U:  state_nxt = ST_MUL_V;
      ST_MUL_V:  state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State machine outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
  end

  // Datapath next values
  always_comb begin
    logic            launch;
    logic [N-1:0]    l_dvd;
    logic [DV_W-1:0] l_dvs;
    div_tag_t        l_tag;

    launch         = 1'b0;
    l_dvd          = dvd_r;
    l_dvs          = dvs_r;
    l_tag          = tag_r;
    play_nxt       = play_r;
    fin_nxt        = fin_r;
    elapsed_nxt    = elapsed_r;
    scale_u_nxt    = scale_u_r;
    scale_v_nxt    = scale_v_r;
    shift_u_nxt    = shift_u_r;
    shift_v_nxt    = shift_v_r;
    action_nxt     = action_r;
    delta_nxt      = delta_r;
    total_nxt      = total_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    dvd_nxt        = dvd_r;
    dvs_nxt        = dvs_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    tag_nxt        = tag_r;
    rew_nxt        = rew_r;
    o_u_scale_nxt  = o_u_scale_r;
    o_v_scale_nxt  = o_v_scale_r;
    o_u_offset_nxt = o_u_offset_r;
    o_v_offset_nxt = o_v_offset_r;
    o_play_nxt     = o_play_r;
    o_fin_nxt      = o_fin_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    unique case (state_r)
      // Capture the transaction
      ST_IDLE: begin
        if (in_ch.valid) begin
          action_nxt = in_ch.action;
          delta_nxt  = in_ch.delta_time;
        end
      end
      // Apply the command to the flags and elapsed time
      ST_EXEC: begin
        case (action_r)
          ACT_TICK: begin
            if (tick_go) begin
              elapsed_nxt = elapsed_sat;
              total_nxt   = TOTAL_W'(cols_r) * TOTAL_W'(rows_r);
            end
          end
          ACT_PLAY: begin
            if (!play_r) begin
              play_nxt    = 1'b1;
              elapsed_nxt = '0;
              fin_nxt     = 1'b0;
            end
          end
          ACT_STOP: begin
            if (play_r) play_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      // Reduce by the period in loop mode, else go straight to the frame
      ST_PERIOD: begin
        launch = 1'b1;
        l_dvd  = elapsed_r;
        if (loop_r) begin
          l_dvs = period;
          l_tag = DT_WRAP;
        end else begin
          l_dvs = DV_W'(intv_r);
          l_tag = DT_FRAME;
        end
      end
      // One restoring step: shift in a dividend bit, subtract if it fits
      ST_DIV: begin
        dvd_nxt = {dvd_r[N-2:0], div_ge};
        rem_nxt = div_ge ? DV_W'(trial - {1'b0, dvs_r}) : trial[DV_W-1:0];
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      // Consume the quotient and remainder, launch the next division if there is one
      ST_POST: begin
        unique case (tag_r)
          DT_WRAP: begin
            elapsed_nxt = N'(rem_r);
            launch      = 1'b1;
            l_dvd       = N'(rem_r);
            l_dvs       = DV_W'(intv_r);
            l_tag       = DT_FRAME;
          end
          DT_FRAME: begin
            if (frame_over) begin
              fin_nxt  = 1'b1;
              play_nxt = 1'b0;
            end else begin
              launch = 1'b1;
              l_dvd  = dvd_r;
              l_dvs  = DV_W'(cols_r);
              l_tag  = DT_COLROW;
            end
          end
          DT_COLROW: begin
            col_nxt = rem_r[COUNT_W-1:0];
            row_nxt = dvd_r[COUNT_W-1:0];
            rew_nxt = 1'b0;
            launch  = 1'b1;
            l_dvd   = N'(UV_ONE);
            l_dvs   = DV_W'(cols_r);
            l_tag   = DT_SCALE_U;
          end
          DT_SCALE_U: begin
            scale_u_nxt = dvd_r[UV_W-1:0];
            launch      = 1'b1;
            l_dvd       = N'(UV_ONE);
            l_dvs       = DV_W'(rows_r);
            l_tag       = DT_SCALE_V;
          end
          DT_SCALE_V: begin
            scale_v_nxt = dvd_r[UV_W-1:0];
          end
          default: ;
        endcase
      end
      // Rewind: offsets to zero, scales from the sheet size
      ST_REWIND: begin
        shift_u_nxt = '0;
        shift_v_nxt = '0;
        if (sheet_ok) begin
          rew_nxt = 1'b1;
          launch  = 1'b1;
          l_dvd   = N'(UV_ONE);
          l_dvs   = DV_W'(cols_r);
          l_tag   = DT_SCALE_U;
        end else begin
          scale_u_nxt = UV_ONE;
          scale_v_nxt = UV_ONE;
        end
      end
      ST_MUL_U: shift_u_nxt = UV_W'(UV_W'(col_r) * scale_u_r);
      ST_MUL_V: shift_v_nxt = UV_W'(UV_W'(row_r) * scale_v_r);
      // Load the output register once it is free
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          o_u_scale_nxt  = scale_u_r;
          o_v_scale_nxt  = scale_v_r;
          o_u_offset_nxt = shift_u_r;
          o_v_offset_nxt = shift_v_r;
          o_play_nxt     = play_r;
          o_fin_nxt      = fin_r;
        end
      end
      default: ;
    endcase

    if (launch) begin
      dvd_nxt = l_dvd;
      dvs_nxt = l_dvs;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(N);
      tag_nxt = l_tag;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      play_r      <= 1'b0;
      fin_r       <= 1'b0;
      elapsed_r   <= '0;
      scale_u_r   <= UV_ONE;
      scale_v_r   <= UV_ONE;
      shift_u_r   <= '0;
      shift_v_r   <= '0;
      cols_r      <= COUNT_W'(1);
      rows_r      <= COUNT_W'(1);
      intv_r      <= '0;
      loop_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      play_r      <= play_nxt;
      fin_r       <= fin_nxt;
      elapsed_r   <= elapsed_nxt;
      scale_u_r   <= scale_u_nxt;
      scale_v_r   <= scale_v_nxt;
      shift_u_r   <= shift_u_nxt;
      shift_v_r   <= shift_v_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_COLUMNS:  cols_r <= cfg_data[COUNT_W-1:0];
          CFG_ROWS:     rows_r <= cfg_data[COUNT_W-1:0];
          CFG_INTERVAL: intv_r <= cfg_data[INTERVAL_W-1:0];
          CFG_LOOP:     loop_r <= cfg_data[0];
        endcase
      end
    end
  end

  // Payload and divider registers
  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    delta_r      <= delta_nxt;
    total_r      <= total_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    dvd_r        <= dvd_nxt;
    dvs_r        <= dvs_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    tag_r        <= tag_nxt;
    rew_r        <= rew_nxt;
    o_u_scale_r  <= o_u_scale_nxt;
    o_v_scale_r  <= o_v_scale_nxt;
    o_u_offset_r <= o_u_offset_nxt;
    o_v_offset_r <= o_v_offset_nxt;
    o_play_r     <= o_play_nxt;
    o_fin_r      <= o_fin_nxt;
  end

  // Drive the result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.u_scale     = o_u_scale_r;
  assign out_ch.v_scale     = o_v_scale_r;
  assign out_ch.u_offset    = o_u_offset_r;
  assign out_ch.v_offset    = o_v_offset_r;
  assign out_ch.is_playing  = o_play_r;
  assign out_ch.is_finished = o_fin_r;

  // Playback and finished never hold together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(play_r && fin_r))
    else $error("playing and finished flags both set");

  // An accepted transaction starts execution on the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_EXEC))
    else $error("accepted transaction did not start");

  // The divider never runs with an exhausted step count
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r != '0))
    else $error("divider step count ran out");

  // A finished result reaches the output register when it is free
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into output register");

endmodule

`default_nettype wire

// ===== tb/sv/sprite_sheet_frame_sequencer_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sprite_sheet_frame_sequencer_top: commands in, UV frames out.
// Depends on sfs_pkg, the channel interfaces in sfs_if.sv and the top level RTL.

module sprite_sheet_frame_sequencer_top_tb;
  import sfs_pkg::*;

  localparam int ELAPSED_BITS = 40;
  localparam longint unsigned ELAPSED_MAX = (64'd1 << ELAPSED_BITS) - 64'd1;
  // Action code 3 has no member in action_t; the block must ignore it
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  // Drain wait, longer than the longest live tick
  localparam int DRAIN_CYCLES = 256;
  localparam int RANDOM_PHASES = 16;
  localparam int CMDS_PER_PHASE = 100;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_t;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [DELTA_W-1:0]  delta;
  } sheet_cmd_t;

  typedef struct {
    logic [UV_W-1:0] u_scale;
    logic [UV_W-1:0] v_scale;
    logic [UV_W-1:0] u_offset;
    logic [UV_W-1:0] v_offset;
    logic            is_playing;
    logic            is_finished;
  } uv_frame_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sfs_in_if  in_bus ();
  sfs_out_if out_bus ();

  sprite_sheet_frame_sequencer_top #(
    .ELAPSED_BITS(ELAPSED_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Sheet registers as the block should hold them
  logic [COUNT_W-1:0]    sheet_cols;
  logic [COUNT_W-1:0]    sheet_rows;
  logic [INTERVAL_W-1:0] interval_units;
  logic                  looping;

  // Sequencer state as the block should hold it
  longint unsigned elapsed_units;
  logic            playing;
  logic            finished;
  logic [UV_W-1:0] scale_u;
  logic [UV_W-1:0] scale_v;
  logic [UV_W-1:0] shift_u;
  logic [UV_W-1:0] shift_v;

  sheet_cmd_t pending_cmds[$];
  uv_frame_t  expected_frames[$];
  idle_kind_t idle_mode;
  int unsigned cmds_queued;
  int unsigned results_seen;
  int unsigned live_ticks;
  int unsigned one_shot_ends;
  int unsigned mismatches;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Back to the first frame: offsets zero, scales from the current counts
  function automatic void rewind_uv();
    if (sheet_cols == 0 || sheet_rows == 0) begin
      scale_u = UV_ONE;
      scale_v = UV_ONE;
    end else begin
      scale_u = UV_W'(64'(UV_ONE) / 64'(sheet_cols));
      scale_v = UV_W'(64'(UV_ONE) / 64'(sheet_rows));
    end
    shift_u = '0;
    shift_v = '0;
  endfunction

  // Advance the sequencer by one time tick
  function automatic void tick_sequencer(logic [DELTA_W-1:0] delta);
    longint unsigned frame_count;
    longint unsigned frame;
    longint unsigned col;
    longint unsigned row;
    if (!playing || sheet_cols == 0 || sheet_rows == 0 || interval_units == 0) return;
    if (!looping && finished) return;
    live_ticks++;
    elapsed_units = elapsed_units + 64'(delta);
    if (elapsed_units > ELAPSED_MAX) elapsed_units = ELAPSED_MAX;
    frame_count = 64'(sheet_cols) * 64'(sheet_rows);
    if (looping) begin
      elapsed_units = elapsed_units % (frame_count * 64'(interval_units));
      frame = elapsed_units / 64'(interval_units);
    end else begin
      frame = elapsed_units / 64'(interval_units);
      if (frame >= frame_count) begin
        rewind_uv();
        finished = 1'b1;
        playing = 1'b0;
        one_shot_ends++;
        return;
      end
    end
    col = frame % 64'(sheet_cols);
    row = frame / 64'(sheet_cols);
    scale_u = UV_W'(64'(UV_ONE) / 64'(sheet_cols));
    scale_v = UV_W'(64'(UV_ONE) / 64'(sheet_rows));
    shift_u = UV_W'(col * 64'(scale_u));
    shift_v = UV_W'(row * 64'(scale_v));
  endfunction

  // Apply one command and return the UV frame the block should report
  function automatic uv_frame_t next_uv_frame(logic [ACTION_W-1:0] action,
                                              logic [DELTA_W-1:0] delta);
    uv_frame_t frame_out;
    if (action == ACT_TICK) begin
      tick_sequencer(delta);
    end else if (action == ACT_PLAY) begin
      if (!playing) begin
        playing = 1'b1;
        elapsed_units = 0;
        finished = 1'b0;
        rewind_uv();
      end
    end else if (action == ACT_STOP) begin
      if (playing) begin
        playing = 1'b0;
        rewind_uv();
      end
    end
    frame_out.u_scale     = scale_u;
    frame_out.v_scale     = scale_v;
    frame_out.u_offset    = shift_u;
    frame_out.v_offset    = shift_v;
    frame_out.is_playing  = playing;
    frame_out.is_finished = finished;
    return frame_out;
  endfunction

  function automatic bit hold_off(idle_kind_t own_kind);
    if (idle_mode == own_kind) return $urandom_range(0, 99) < 75;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 35;
    return 1'b0;
  endfunction

  // Present queued commands; predict each one as its transaction completes
  always @(posedge clk) begin : drive_commands
    sheet_cmd_t cmd;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        expected_frames.push_back(next_uv_frame(in_bus.action, in_bus.delta_time));
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_cmds.size() != 0 && !hold_off(IDLE_SENDER)) begin
          cmd = pending_cmds.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.action     <= cmd.action;
          in_bus.delta_time <= cmd.delta;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) out_bus.ready <= 1'b0;
    else out_bus.ready <= !hold_off(IDLE_RECEIVER);
  end

  function automatic void check_field(string name, logic [UV_W-1:0] want,
                                      logic [UV_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    uv_frame_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        $error("result transaction with no command outstanding");
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("u_scale", want.u_scale, out_bus.u_scale);
        check_field("v_scale", want.v_scale, out_bus.v_scale);
        check_field("u_offset", want.u_offset, out_bus.u_offset);
        check_field("v_offset", want.v_offset, out_bus.v_offset);
        check_field("is_playing", UV_W'(want.is_playing), UV_W'(out_bus.is_playing));
        check_field("is_finished", UV_W'(want.is_finished), UV_W'(out_bus.is_finished));
      end
    end
  end

  function automatic void push_cmd(logic [ACTION_W-1:0] action, logic [DELTA_W-1:0] delta);
    sheet_cmd_t cmd;
    cmd.action = action;
    cmd.delta  = delta;
    pending_cmds.push_back(cmd);
    cmds_queued++;
  endfunction

  // Mostly ticks with deltas near the frame interval, plus play, stop and noise
  function automatic void queue_random_cmd();
    int unsigned pick;
    longint unsigned span;
    pick = $urandom_range(0, 99);
    span = 64'(interval_units) * 3 / 2 + 1;
    if (span > 65535) span = 65535;
    if (pick < 80) begin
      if ($urandom_range(0, 3) == 0) push_cmd(ACT_TICK, DELTA_W'($urandom));
      else push_cmd(ACT_TICK, DELTA_W'($urandom_range(0, int'(span))));
    end else if (pick < 88) begin
      push_cmd(ACT_PLAY, DELTA_W'($urandom));
    end else if (pick < 96) begin
      push_cmd(ACT_STOP, DELTA_W'($urandom));
    end else begin
      push_cmd(ACT_UNUSED, DELTA_W'($urandom));
    end
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       return '0;
      1:       return 7'd64;
      2:       return 7'd127;
      3:       return COUNT_W'($urandom_range(65, 127));
      default: return COUNT_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [INTERVAL_W-1:0] pick_interval();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return '0;
      1:       return '1;
      2:       return INTERVAL_W'($urandom_range(1, 24'hFFFFFF));
      default: return INTERVAL_W'($urandom_range(1, 3000));
    endcase
  endfunction

  // Call right after a rising edge; the register is written at the next one
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_COLUMNS:  sheet_cols     = data[COUNT_W-1:0];
      CFG_ROWS:     sheet_rows     = data[COUNT_W-1:0];
      CFG_INTERVAL: interval_units = data[INTERVAL_W-1:0];
      CFG_LOOP:     looping        = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] cols_word, logic [CFG_DATA_W-1:0] rows_word,
                           logic [CFG_DATA_W-1:0] interval_word,
                           logic [CFG_DATA_W-1:0] loop_word);
    write_reg(CFG_COLUMNS, cols_word);
    write_reg(CFG_ROWS, rows_word);
    write_reg(CFG_INTERVAL, interval_word);
    write_reg(CFG_LOOP, loop_word);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued command has produced its result
  task automatic wait_drained();
    while (results_seen < cmds_queued) @(posedge clk);
  endtask

  initial begin : run_phases
    logic [CFG_DATA_W-1:0] upper_noise;
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_bus.valid      = 1'b0;
    in_bus.action     = '0;
    in_bus.delta_time = '0;
    out_bus.ready     = 1'b0;
    idle_mode         = IDLE_NONE;
    cmds_queued       = 0;
    results_seen      = 0;
    live_ticks        = 0;
    one_shot_ends     = 0;
    mismatches        = 0;
    // Reset values of the registers and the sequencer
    sheet_cols     = 7'd1;
    sheet_rows     = 7'd1;
    interval_units = '0;
    looping        = 1'b0;
    elapsed_units  = 0;
    playing        = 1'b0;
    finished       = 1'b0;
    scale_u        = UV_ONE;
    scale_v        = UV_ONE;
    shift_u        = '0;
    shift_v        = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sheet, frozen interval: ignored tick, stop and play edge cases
    push_cmd(ACT_TICK, 16'd5);
    push_cmd(ACT_STOP, 16'd0);
    push_cmd(ACT_PLAY, 16'd0);
    push_cmd(ACT_TICK, 16'd100);
    push_cmd(ACT_PLAY, 16'hFFFF);
    push_cmd(ACT_STOP, 16'd0);
    push_cmd(ACT_UNUSED, 16'd0);
    wait_drained();

    // One-shot 4 x 3: step frames, run past the end, replay, stop
    configure(24'd4, 24'd3, 24'd10, 24'd0);
    push_cmd(ACT_PLAY, 16'd0);
    push_cmd(ACT_TICK, 16'd0);
    push_cmd(ACT_TICK, 16'd7);
    push_cmd(ACT_TICK, 16'd10);
    push_cmd(ACT_TICK, 16'd25);
    push_cmd(ACT_TICK, 16'hFFFF);
    push_cmd(ACT_TICK, 16'd3);
    push_cmd(ACT_PLAY, 16'd0);
    push_cmd(ACT_STOP, 16'd0);
    wait_drained();

    // Looping 3 x 2 with unit interval: wrap on large deltas
    configure(24'd3, 24'd2, 24'd1, 24'd1);
    push_cmd(ACT_PLAY, 16'd0);
    push_cmd(ACT_TICK, 16'hFFFF);
    push_cmd(ACT_TICK, 16'h5555);
    push_cmd(ACT_TICK, 16'hAAAA);
    push_cmd(ACT_UNUSED, 16'hFFFF);
    wait_drained();

    // No valid sheet: play rewinds to full scale, ticks do nothing
    configure(24'd0, 24'd64, 24'd1, 24'd0);
    push_cmd(ACT_PLAY, 16'd0);
    push_cmd(ACT_TICK, 16'd1);
    wait_drained();

    // Widest interval with a large looping sheet
    configure(24'd127, 24'd64, 24'hFFFFFF, 24'd1);
    push_cmd(ACT_PLAY, 16'd0);
    push_cmd(ACT_TICK, 16'hFFFF);
    wait_drained();

    // Random phases: new sheet settings and idling pattern each time
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_mode = idle_kind_t'(phase % 4);
      upper_noise = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom) : '0;
      upper_noise[COUNT_W-1:0] = '0;
      if (phase == 0)
        configure(24'd127, 24'd127, 24'd1, 24'd0);
      else
        configure(upper_noise | CFG_DATA_W'(pick_count()),
                  upper_noise | CFG_DATA_W'(pick_count()),
                  CFG_DATA_W'(pick_interval()),
                  {upper_noise[CFG_DATA_W-1:1], 1'($urandom_range(0, 1))});
      push_cmd(ACT_PLAY, DELTA_W'($urandom));
      repeat (CMDS_PER_PHASE - 1) queue_random_cmd();
      wait_drained();
    end

    // Let any stray result show up before closing
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $error("%0d predicted results never arrived", expected_frames.size());
      mismatches++;
    end

    $display("Checked %0d results for %0d commands over %0d sheet settings;",
             results_seen, cmds_queued, RANDOM_PHASES + 5);
    $display("%0d ticks moved the animation, %0d one-shot plays ran to the end.",
             live_ticks, one_shot_ends);
    if (mismatches == 0) begin
      $display("sprite_sheet_frame_sequencer_top_tb: PASS");
    end else begin
      $display("sprite_sheet_frame_sequencer_top_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("sprite_sheet_frame_sequencer_top_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sfs_pkg.sv
rtl/sfs_if.sv
rtl/sprite_sheet_frame_sequencer_top.sv
tb/sv/sprite_sheet_frame_sequencer_top_tb.sv
